@@ hdl/pls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// Shared constants for the streaming 2-D pooling block.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int MAX_WIDTH    = 128;
    localparam int MAX_CHANNELS = 32;
    localparam int MAX_POOL     = 4;
    localparam int MAX_HEIGHT   = 1024;

    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 21;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int CH_W     = $clog2(MAX_CHANNELS);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int ADDR_W   = COL_W + CH_W;
    localparam int DEPTH    = MAX_WIDTH * MAX_CHANNELS;
    localparam int CNT_W    = 5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_POOL_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POOL_SIZE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

endpackage

@@ hdl/pls_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/pls_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_div
// Bit-serial signed divide by a small window count, truncating toward zero,
// with the quotient saturated to 16 bits.
// ----------------------------------------------------------------------------
module pls_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [pls_pkg::ACC_W-1:0]    dividend,
    input  logic [pls_pkg::CNT_W-1:0]           divisor,
    output logic                          done,
    output logic signed [pls_pkg::SAMPLE_W-1:0] quotient
);
    import pls_pkg::*;

    localparam int STEP_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]   num_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   div_reg;
    logic               neg_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W:0]     rem_shift;
    logic               fits;
    logic [ACC_W-1:0]   mag;

    assign rem_shift = {rem_reg, num_reg[ACC_W-1]};
    assign fits      = rem_shift >= {1'b0, div_reg};
    assign mag       = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(ACC_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= mag;
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= dividend[ACC_W-1];
        end else if (busy_reg) begin
            num_reg <= {num_reg[ACC_W-2:0], fits};
            rem_reg <= fits ? CNT_W'(rem_shift - {1'b0, div_reg}) : rem_shift[CNT_W-1:0];
        end
    end

    always_comb begin
        if (neg_reg) begin
            if (num_reg > ACC_W'(32768)) begin
                quotient = 16'sh8000;
            end else begin
                quotient = SAMPLE_W'(-num_reg);
            end
        end else begin
            if (num_reg > ACC_W'(32767)) begin
                quotient = 16'sh7fff;
            end else begin
                quotient = num_reg[SAMPLE_W-1:0];
            end
        end
    end

    assign done = done_reg;

endmodule

@@ hdl/pooling_2d_stream.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pooling_2d_stream
// Streaming 2-D max / average pooling over non-overlapping square windows.
//
// Samples enter on s_ (valid/ready), row by row, column by column, channel
// innermost. Pooled results leave on m_ (valid/ready); m_image_end marks the
// last result of an image. Registers are written on the cfg_ channel; the user
// must write them only while the block is idle, as the block does not enforce it.
// One accumulator per (window start column, channel) sits in a 4096-entry RAM
// with a registered read. A sample's accumulator is read as it is taken in IDLE,
// then updated and written back in READ; a result then goes through OUT in max
// mode, or through DIV, awaiting the bit-serial divider, and OUT in average mode.
// Results go to an output register; the next sample is taken while a result
// waits there, and the block holds only when a new result finds it still full.
// Synchronous reset clears positions and restores register defaults; the
// accumulator RAM needs no clearing since every window starts by writing.
// ----------------------------------------------------------------------------
module pooling_2d_stream (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pls_pkg::SAMPLE_W-1:0]  s_sample_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pls_pkg::SAMPLE_W-1:0]  m_pooled_value,
    output logic                                 m_image_end,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pls_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [pls_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import pls_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]  state_reg, state_next;

    logic        mode_reg;
    logic [2:0]  size_reg;
    logic [10:0] height_reg;
    logic [7:0]  width_reg;
    logic [5:0]  chan_reg;

    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [CH_W-1:0]  ch_reg;
    logic [1:0]       row_ph_reg;
    logic [1:0]       col_ph_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] max_val_reg;
    logic                       end_reg;
    logic signed [SAMPLE_W-1:0] m_value_reg;
    logic                       m_end_reg;
    logic                       m_valid_reg;

    logic [2:0]  p_eff;
    logic [10:0] h_eff;
    logic [7:0]  w_eff;
    logic [5:0]  c_eff;

    logic [COL_W-1:0] start_col;
    logic [ROW_W-1:0] start_row;
    logic [ADDR_W-1:0] addr;
    logic last_ch, last_col, last_row, col_ph_end, row_ph_end, emit;
    logic signed [ACC_W-1:0] mem_rd, acc, s_ext;
    logic [7:0]  left_w;
    logic [10:0] left_h;
    logic [2:0]  ext_w, ext_h;
    logic [CNT_W-1:0] count;
    logic div_start, div_done;
    logic signed [SAMPLE_W-1:0] div_q;
    logic accept, out_load;

    // effective register values
    always_comb begin
        p_eff = (size_reg == 3'd0) ? 3'd1 : (size_reg > 3'(MAX_POOL)) ? 3'(MAX_POOL) : size_reg;
        h_eff = (height_reg == 11'd0) ? 11'd1 :
                (height_reg > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : height_reg;
        w_eff = (width_reg == 8'd0) ? 8'd1 :
                (width_reg > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : width_reg;
        c_eff = (chan_reg == 6'd0) ? 6'd1 :
                (chan_reg > 6'(MAX_CHANNELS)) ? 6'(MAX_CHANNELS) : chan_reg;
    end

    assign start_col = ({5'd0, col_ph_reg} <= col_reg) ? col_reg - COL_W'(col_ph_reg) : '0;
    assign start_row = ({8'd0, row_ph_reg} <= row_reg) ? row_reg - ROW_W'(row_ph_reg) : '0;
    assign addr      = {start_col, ch_reg};

    assign last_ch    = {1'b0, ch_reg}  >= c_eff - 6'd1;
    assign last_col   = {1'b0, col_reg} >= w_eff - 8'd1;
    assign last_row   = {1'b0, row_reg} >= h_eff - 11'd1;
    assign col_ph_end = {1'b0, col_ph_reg} >= p_eff - 3'd1;
    assign row_ph_end = {1'b0, row_ph_reg} >= p_eff - 3'd1;
    assign emit       = (col_ph_end || last_col) && (row_ph_end || last_row);

    assign s_ext = ACC_W'(sample_reg);

    always_comb begin
        if (row_ph_reg == 2'd0 && col_ph_reg == 2'd0) begin
            acc = s_ext;
        end else if (!mode_reg) begin
            acc = (s_ext > mem_rd) ? s_ext : mem_rd;
        end else begin
            acc = mem_rd + s_ext;
        end
    end

    // element count of a window clipped at the right and bottom edges
    always_comb begin
        left_w = ({1'b0, start_col} < w_eff) ? w_eff - {1'b0, start_col} : 8'd1;
        left_h = ({1'b0, start_row} < h_eff) ? h_eff - {1'b0, start_row} : 11'd1;
        ext_w  = (left_w < 8'(p_eff)) ? left_w[2:0] : p_eff;
        ext_h  = (left_h < 11'(p_eff)) ? left_h[2:0] : p_eff;
        count  = {2'b0, ext_w} * {2'b0, ext_h};
    end

    pls_ram #(
        .WIDTH(ACC_W),
        .DEPTH(DEPTH)
    ) u_acc_ram (
        .aclk   (aclk),
        .wr_en  (state_reg == ST_READ),
        .wr_addr(addr),
        .wr_data(acc),
        .rd_addr(addr),
        .rd_data(mem_rd)
    );

    assign div_start = (state_reg == ST_READ) && emit && mode_reg;

    pls_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(acc),
        .divisor (count),
        .done    (div_done),
        .quotient(div_q)
    );

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_READ;
            end
            ST_READ: begin
                if (!emit) state_next = ST_IDLE;
                else if (mode_reg) state_next = ST_DIV;
                else state_next = ST_OUT;
            end
            ST_DIV: begin
                if (div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= 1'b0;
            size_reg    <= 3'd2;
            height_reg  <= 11'd1;
            width_reg   <= 8'd1;
            chan_reg    <= 6'd1;
            row_reg     <= '0;
            col_reg     <= '0;
            ch_reg      <= '0;
            row_ph_reg  <= '0;
            col_ph_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_POOL_MODE:     mode_reg   <= cfg_data[0];
                    REG_POOL_SIZE:     size_reg   <= cfg_data[2:0];
                    REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                    REG_IMAGE_WIDTH:   width_reg  <= cfg_data[7:0];
                    REG_CHANNEL_COUNT: chan_reg   <= cfg_data[5:0];
                    default: ;
                endcase
            end
            // advance stream position
            if (state_reg == ST_READ) begin
                if (!last_ch) begin
                    ch_reg <= ch_reg + 1'b1;
                end else begin
                    ch_reg <= '0;
                    if (!last_col) begin
                        col_reg    <= col_reg + 1'b1;
                        col_ph_reg <= col_ph_end ? 2'd0 : col_ph_reg + 2'd1;
                    end else begin
                        col_reg    <= '0;
                        col_ph_reg <= '0;
                        if (!last_row) begin
                            row_reg    <= row_reg + 1'b1;
                            row_ph_reg <= row_ph_end ? 2'd0 : row_ph_reg + 2'd1;
                        end else begin
                            row_reg    <= '0;
                            row_ph_reg <= '0;
                        end
                    end
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample_value;
        end
        if (state_reg == ST_READ) begin
            max_val_reg <= acc[SAMPLE_W-1:0];
            end_reg     <= last_ch && last_col && last_row;
        end
        if (out_load) begin
            m_value_reg <= mode_reg ? div_q : max_val_reg;
            m_end_reg   <= end_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pooled_value = m_value_reg;
    assign m_image_end    = m_end_reg;

endmodule

@@ dv/pooling_2d_stream_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pooling_2d_stream_tb
// Self-checking testbench for the streaming 2-D pooling block.
//
// Streams whole images through the block under a range of register settings:
// both pooling modes, all window sizes, edge-clipped windows, out-of-range
// register values and ignored register indexes. A scoreboard predicts every
// pooled result and its image-end flag and checks them in order. Both sides
// idle in random bursts; the last part of the run runs at full rate.
// Registers change only between images, once the block has gone quiet.
// ----------------------------------------------------------------------------
module pooling_2d_stream_tb;

    import pls_pkg::*;

    class pool_scoreboard;
        typedef struct {
            logic signed [SAMPLE_W-1:0] value;
            logic                       last;
        } pooled_t;

        logic                   mode_r;
        logic [2:0]             size_r;
        logic [10:0]            height_r;
        logic [7:0]             width_r;
        logic [5:0]             chans_r;
        int unsigned            row_pos, col_pos, ch_pos, row_ph, col_ph;
        int                     window_acc [DEPTH];
        pooled_t                pending_q [$];
        int                     errors;

        function new();
            mode_r   = 1'b0;
            size_r   = 3'd2;
            height_r = 11'd1;
            width_r  = 8'd1;
            chans_r  = 6'd1;
            row_pos  = 0;
            col_pos  = 0;
            ch_pos   = 0;
            row_ph   = 0;
            col_ph   = 0;
            errors   = 0;
            foreach (window_acc[i]) window_acc[i] = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_POOL_MODE:     mode_r   = d[0];
                REG_POOL_SIZE:     size_r   = d[2:0];
                REG_IMAGE_HEIGHT:  height_r = d[10:0];
                REG_IMAGE_WIDTH:   width_r  = d[7:0];
                REG_CHANNEL_COUNT: chans_r  = d[5:0];
                default: ;
            endcase
        endfunction

        function int unsigned clip(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned extent(int unsigned lim, int unsigned start, int unsigned p);
            int unsigned left;
            left = (start < lim) ? lim - start : 1;
            return (left < p) ? left : p;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] smp);
            int unsigned p, h, w, c, start_col, start_row, addr;
            int          acc, avg;
            bit          last_ch, last_col, last_row, col_end, row_end;
            pooled_t     res;
            p = clip(size_r, MAX_POOL);
            h = clip(height_r, MAX_HEIGHT);
            w = clip(width_r, MAX_WIDTH);
            c = clip(chans_r, MAX_CHANNELS);
            start_col = (col_ph <= col_pos) ? col_pos - col_ph : 0;
            start_row = (row_ph <= row_pos) ? row_pos - row_ph : 0;
            addr = (start_col % MAX_WIDTH) * MAX_CHANNELS + (ch_pos % MAX_CHANNELS);
            last_ch  = ch_pos >= c - 1;
            last_col = col_pos >= w - 1;
            last_row = row_pos >= h - 1;
            col_end  = col_ph >= p - 1;
            row_end  = row_ph >= p - 1;
            if (row_ph == 0 && col_ph == 0) begin
                acc = smp;
            end else if (mode_r == 1'b0) begin
                acc = (smp > window_acc[addr]) ? smp : window_acc[addr];
            end else begin
                acc = window_acc[addr] + smp;
            end
            window_acc[addr] = acc;
            if ((col_end || last_col) && (row_end || last_row)) begin
                avg = acc;
                if (mode_r) begin
                    avg = acc / int'(extent(w, start_col, p) * extent(h, start_row, p));
                    if (avg > 32767) avg = 32767;
                    if (avg < -32768) avg = -32768;
                end
                res.value = avg[SAMPLE_W-1:0];
                res.last  = last_ch && last_col && last_row;
                pending_q.push_back(res);
            end
            if (!last_ch) begin
                ch_pos++;
            end else begin
                ch_pos = 0;
                if (!last_col) begin
                    col_pos++;
                    col_ph = col_end ? 0 : col_ph + 1;
                end else begin
                    col_pos = 0;
                    col_ph  = 0;
                    if (!last_row) begin
                        row_pos++;
                        row_ph = row_end ? 0 : row_ph + 1;
                    end else begin
                        row_pos = 0;
                        row_ph  = 0;
                    end
                end
            end
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] value, logic last);
            pooled_t exp_res;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value %0d end %0d",
                         $realtime, value, last);
                errors++;
                return;
            end
            exp_res = pending_q.pop_front();
            if (value !== exp_res.value) begin
                $display("%0t: pooled_value mismatch, expected %0d, actual %0d",
                         $realtime, exp_res.value, value);
                errors++;
            end
            if (last !== exp_res.last) begin
                $display("%0t: image_end mismatch, expected %0d, actual %0d",
                         $realtime, exp_res.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic signed [SAMPLE_W-1:0]  s_sample_value;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [SAMPLE_W-1:0]  m_pooled_value;
    logic                        m_image_end;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    pool_scoreboard sb;
    bit             idle_on;
    int             random_items;

    pooling_2d_stream dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pooled_value (m_pooled_value),
        .m_image_end    (m_image_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("** pooling_2d_stream: FAILED **");
        $finish;
    end

    // result side: random stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_pooled_value, m_image_end);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, d);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(logic signed [SAMPLE_W-1:0] smp);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_value <= smp;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(smp);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic configure(logic mode, logic [2:0] size, logic [10:0] h,
                             logic [7:0] w, logic [5:0] c);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_POOL_MODE, {junk[10:1], mode});
        write_reg(REG_POOL_SIZE, {junk[10:3], size});
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_IMAGE_WIDTH, {junk[10:8], w});
        write_reg(REG_CHANNEL_COUNT, {junk[10:6], c});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_INDEX_W'($urandom_range(5, 7)), junk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int flavor);
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return (flavor == 1) ? 16'sh8000 : 16'sh7fff;
            3: return SAMPLE_W'($urandom_range(0, 6)) - 16'sd3;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic run_images(int images, int flavor, bit counted);
        int unsigned total;
        total = sb.clip(sb.height_r, MAX_HEIGHT) * sb.clip(sb.width_r, MAX_WIDTH)
                * sb.clip(sb.chans_r, MAX_CHANNELS) * images;
        repeat (total) begin
            send_sample(pick_sample(flavor));
            if (counted) random_items++;
            if (random_items > 330) idle_on = 1'b0;
        end
        drain();
    endtask

    initial begin
        logic signed [SAMPLE_W-1:0] avg_set [9];
        sb = new();
        idle_on        = 1'b1;
        random_items   = 0;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_sample_value <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: max, 1x1 image, window clipped by both edges
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        drain();

        // average over a 3x3 image with 2x2 windows, negative truncation
        avg_set = '{16'sh8000, 16'sh8000, -16'sd3, 16'sh8000, 16'sh8000, 16'sd5,
                    -16'sd7, 16'sd2, 16'sh7fff};
        configure(1'b1, 3'd2, 11'd3, 8'd3, 6'd1);
        foreach (avg_set[i]) send_sample(avg_set[i]);
        drain();

        // max with 3x3 windows over 2x2x2, all-negative channel
        configure(1'b0, 3'd3, 11'd2, 8'd2, 6'd2);
        send_sample(-16'sd9);  send_sample(16'sh8000);
        send_sample(-16'sd4);  send_sample(16'sh8000);
        send_sample(-16'sd12); send_sample(16'sh8000);
        send_sample(-16'sd1);  send_sample(16'sh8000);
        drain();

        // register extremes and out-of-range values
        configure(1'b1, 3'd7, 11'd5, 8'd1, 6'd1);
        run_images(1, 1, 1'b0);
        configure(1'b0, 3'd0, 11'd1, 8'd255, 6'd1);
        run_images(1, 0, 1'b0);
        configure(1'b1, 3'd4, 11'd1, 8'd3, 6'd63);
        run_images(1, 2, 1'b0);
        configure(1'b1, 3'd4, 11'd4, 8'd4, 6'd2);
        run_images(1, 1, 1'b0);
        configure(1'b0, 3'd1, 11'd0, 8'd0, 6'd0);
        run_images(2, 0, 1'b0);

        while (random_items < 400) begin
            configure(1'($urandom), ($urandom_range(0, 5) == 0) ? 3'($urandom) :
                      3'($urandom_range(1, 4)),
                      11'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                      6'($urandom_range(0, 3)));
            run_images($urandom_range(1, 2), $urandom_range(0, 2), 1'b1);
        end

        if (sb.errors == 0) begin
            $display("** pooling_2d_stream: PASSED **");
        end else begin
            $display("** pooling_2d_stream: FAILED **");
        end
        $finish;
    end

endmodule
